>>> hdl/admx_pkg.sv
// admx_pkg: shared sizes, codes, types and the round/saturate helper
// for the ambisonics demixing block; used by every file in hdl/ but admx_ram
`default_nettype none

package admx_pkg;

    localparam int MAX_OUT_CHANNELS = 16;
    localparam int MAX_IN_COLUMNS   = 16;
    localparam int SAMPLE_BITS      = 24;
    localparam int COEF_BITS        = 16;
    localparam int COEF_DEPTH       = 256;
    localparam int COEF_AW          = $clog2(COEF_DEPTH);

    localparam int OP_BITS      = 2;
    localparam int INDEX_BITS   = 8;
    localparam int MAP_BITS     = 8;
    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CNT_BITS     = 5;
    localparam int OUT_CH_BITS  = 4;

    localparam int COL_W = (MAX_IN_COLUMNS > 1) ? $clog2(MAX_IN_COLUMNS) : 1;
    localparam int ROW_W = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

    localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + COL_W;
    localparam int FRAC   = COEF_BITS - 1;
    localparam int SH_W   = ACC_W + 1 - FRAC;

    localparam int IN_TDATA_W  = ((INDEX_BITS + COEF_BITS + MAP_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_CH_BITS + SAMPLE_BITS + 7) / 8) * 8;

    // input tdata field offsets, lowest first
    localparam int IDX_LSB  = 0;
    localparam int COEF_LSB = IDX_LSB + INDEX_BITS;
    localparam int MAP_LSB  = COEF_LSB + COEF_BITS;
    localparam int SMP_LSB  = MAP_LSB + MAP_BITS;

    localparam logic [MAP_BITS-1:0] SILENT_ENTRY = MAP_BITS'(255);
    localparam logic [CNT_BITS-1:0] CNT_MAX      = '1;
    localparam int                  DRAIN_LAST   = 2;

    localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MAP    = 2'd2;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_MONO = 2'd1;
    localparam logic [1:0] MODE_PROJ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_COLS = 2'd2;

    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [ACC_W:0]  ROUND_BIAS = (ACC_W + 1)'(64'sd1 <<< (FRAC - 1));

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

    // round half up, floor shift, saturate to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]  biased;
        logic signed [SH_W-1:0] shifted;
        begin
            biased  = $signed({acc[ACC_W-1], acc}) + ROUND_BIAS;
            shifted = biased[ACC_W:FRAC];
            if (shifted > SAT_HI) begin
                round_sat = SAT_HI[SAMPLE_BITS-1:0];
            end else if (shifted < SAT_LO) begin
                round_sat = SAT_LO[SAMPLE_BITS-1:0];
            end else begin
                round_sat = shifted[SAMPLE_BITS-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/ambisonics_demix_matrix_unit.sv
// ambisonics_demix_matrix_unit: top level of the demixing block
// depends on admx_pkg, admx_ram, admx_cell, admx_mac
//
// usage: the input stream carries one beat per op. tuser selects sample,
// coefficient load or map load; tlast marks the final sample of an instant.
// samples are written into a ring of 16 cells; on the final sample the block
// drops s_axis_tready and works through the output rows. for every row the
// ring rotates once around while one multiply-accumulate per cycle runs
// against the coefficient ram, then the drain state lets the multiplier and
// accumulator finish and the result is rounded. mono and passthrough rows
// pick their sample during the same rotation. a channel count mismatch
// gives one error beat right away. each row waits in the output register
// until m_axis_tready; the next row starts only after the beat is taken,
// and tready on the input side rises again after the final row is taken.
// reset clears the state machine, the column counter and the configuration
// (mode passthrough, one row, one column); coefficients, map entries and
// samples hold nothing defined until written.
`default_nettype none

module ambisonics_demix_matrix_unit (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic [admx_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [admx_pkg::CFG_W-1:0]              i_cfg_data,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // index, coef, map_value, sample
    input  wire logic [admx_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
    // op
    input  wire logic [admx_pkg::OP_BITS-1:0]            s_axis_tuser,
    input  wire logic                                    s_axis_tlast,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // out_channel, out_sample, zero fill
    output logic [admx_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,
    // error
    output logic                                         m_axis_tuser,
    output logic                                         m_axis_tlast
);

    localparam int NCELL = admx_pkg::MAX_IN_COLUMNS;
    localparam int SB    = admx_pkg::SAMPLE_BITS;

    // configuration
    logic [1:0]                 r_mode;
    logic [admx_pkg::CFG_W-1:0] r_out_channels;
    logic [admx_pkg::CFG_W-1:0] r_in_columns;

    // control
    admx_pkg::t_state            r_state, n_state;
    logic [admx_pkg::CNT_BITS-1:0] r_col_cnt;
    logic [admx_pkg::CFG_W-1:0]  r_rows;
    logic [admx_pkg::ROW_W-1:0]  r_row;
    logic [admx_pkg::COL_W-1:0]  r_step;
    logic [1:0]                  r_drain;
    logic [admx_pkg::COEF_AW-1:0] r_addr;

    // output register
    logic                          r_out_valid;
    logic [admx_pkg::OUT_CH_BITS-1:0] r_out_ch;
    logic signed [SB-1:0]          r_out_sample;
    logic                          r_out_last;
    logic                          r_out_err;

    // datapath
    logic [admx_pkg::MAP_BITS-1:0] r_map [admx_pkg::MAX_OUT_CHANNELS];
    logic signed [SB-1:0]          r_samp_d;
    logic signed [SB-1:0]          r_copy;
    logic signed [SB-1:0]          cell_q [NCELL];

    // input fields
    logic [admx_pkg::OP_BITS-1:0]    in_op;
    logic [admx_pkg::INDEX_BITS-1:0] in_index;
    logic [admx_pkg::COEF_BITS-1:0]  in_coef;
    logic [admx_pkg::MAP_BITS-1:0]   in_map;
    logic signed [SB-1:0]            in_sample;

    logic                            in_fire;
    logic                            out_fire;
    logic                            sample_fire;
    logic                            final_fire;
    logic [admx_pkg::CNT_BITS-1:0]   cnt_next;
    logic                            count_bad;
    logic [admx_pkg::CFG_W-1:0]      rows_clamped;
    logic                            sweeping;
    logic                            step_last;
    logic                            row_last;
    logic                            copy_en;
    logic [admx_pkg::COL_W-1:0]      copy_tgt;
    logic [admx_pkg::MAP_BITS-1:0]   map_entry;
    logic                            proj_mode;
    logic                            load_row;
    logic                            next_row;
    logic [admx_pkg::COEF_BITS-1:0]  coef_q;
    logic signed [admx_pkg::ACC_W-1:0] acc;
    admx_pkg::t_mac_ctrl             mac_ctrl;
    logic signed [SB-1:0]            row_result;

    assign in_op     = s_axis_tuser;
    assign in_index  = s_axis_tdata[admx_pkg::IDX_LSB +: admx_pkg::INDEX_BITS];
    assign in_coef   = s_axis_tdata[admx_pkg::COEF_LSB +: admx_pkg::COEF_BITS];
    assign in_map    = s_axis_tdata[admx_pkg::MAP_LSB +: admx_pkg::MAP_BITS];
    assign in_sample = $signed(s_axis_tdata[admx_pkg::SMP_LSB +: SB]);

    assign s_axis_tready = (r_state == admx_pkg::ST_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign sample_fire   = in_fire && (in_op == admx_pkg::OP_SAMPLE);
    assign final_fire    = sample_fire && s_axis_tlast;

    assign cnt_next  = (r_col_cnt == admx_pkg::CNT_MAX) ? r_col_cnt
                                                         : r_col_cnt + 1'b1;
    assign count_bad = (cnt_next != r_in_columns)
                    || (32'(r_in_columns) > 32'(admx_pkg::MAX_IN_COLUMNS));

    always_comb begin
        if (r_out_channels == '0) begin
            rows_clamped = admx_pkg::CFG_W'(1);
        end else if (32'(r_out_channels) > 32'(admx_pkg::MAX_OUT_CHANNELS)) begin
            rows_clamped = admx_pkg::CFG_W'(admx_pkg::MAX_OUT_CHANNELS);
        end else begin
            rows_clamped = r_out_channels;
        end
    end

    assign sweeping  = (r_state == admx_pkg::ST_SWEEP);
    assign step_last = (r_step == admx_pkg::COL_W'(NCELL - 1));
    assign row_last  = (32'(r_row) + 32'd1 == 32'(r_rows));
    assign proj_mode = (r_mode == admx_pkg::MODE_PROJ);

    // which ring position a mono or passthrough row picks
    assign map_entry = r_map[r_row];
    always_comb begin
        if (r_mode == admx_pkg::MODE_MONO) begin
            copy_en  = (map_entry != admx_pkg::SILENT_ENTRY)
                    && (32'(map_entry) < 32'(r_in_columns));
            copy_tgt = map_entry[admx_pkg::COL_W-1:0];
        end else begin
            copy_en  = (32'(r_row) < 32'(r_in_columns));
            copy_tgt = admx_pkg::COL_W'(r_row);
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= admx_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        load_row = 1'b0;
        next_row = 1'b0;
        unique case (r_state)
            admx_pkg::ST_LOAD: begin
                if (final_fire) begin
                    if (count_bad) begin
                        n_state = admx_pkg::ST_OUT;
                    end else begin
                        n_state  = admx_pkg::ST_SWEEP;
                        load_row = 1'b1;
                    end
                end
            end
            admx_pkg::ST_SWEEP: begin
                if (step_last) begin
                    n_state = admx_pkg::ST_DRAIN;
                end
            end
            admx_pkg::ST_DRAIN: begin
                if (r_drain == 2'(admx_pkg::DRAIN_LAST)) begin
                    n_state = admx_pkg::ST_OUT;
                end
            end
            admx_pkg::ST_OUT: begin
                if (out_fire) begin
                    if (r_out_last) begin
                        n_state = admx_pkg::ST_LOAD;
                    end else begin
                        n_state  = admx_pkg::ST_SWEEP;
                        next_row = 1'b1;
                    end
                end
            end
            default: n_state = admx_pkg::ST_LOAD;
        endcase
    end

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= admx_pkg::MODE_PASS;
            r_out_channels <= admx_pkg::CFG_W'(1);
            r_in_columns   <= admx_pkg::CFG_W'(1);
            r_col_cnt      <= '0;
            r_out_valid    <= 1'b0;
            r_rows         <= admx_pkg::CFG_W'(1);
            r_row          <= '0;
            r_step         <= '0;
            r_drain        <= '0;
            r_addr         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    admx_pkg::REG_MODE:    r_mode         <= i_cfg_data[1:0];
                    admx_pkg::REG_OUT_CH:  r_out_channels <= i_cfg_data;
                    admx_pkg::REG_IN_COLS: r_in_columns   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (sample_fire) begin
                r_col_cnt <= s_axis_tlast ? '0 : cnt_next;
            end

            if (load_row) begin
                r_rows <= rows_clamped;
                r_row  <= '0;
                r_addr <= '0;
                r_step <= '0;
            end else if (next_row) begin
                r_row  <= r_row + 1'b1;
                r_addr <= admx_pkg::COEF_AW'(r_row) + 1'b1;
                r_step <= '0;
            end else if (sweeping) begin
                // next column of this row sits rows entries further on
                r_step <= r_step + 1'b1;
                r_addr <= r_addr + admx_pkg::COEF_AW'(r_rows);
            end

            if (r_state == admx_pkg::ST_DRAIN) begin
                r_drain <= r_drain + 1'b1;
            end else begin
                r_drain <= '0;
            end

            if (out_fire) begin
                r_out_valid <= 1'b0;
            end else if ((final_fire && count_bad)
                      || (r_state == admx_pkg::ST_DRAIN
                          && r_drain == 2'(admx_pkg::DRAIN_LAST))) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // map entries, copy capture and output payload
    assign row_result = proj_mode ? admx_pkg::round_sat(acc)
                                  : (copy_en ? r_copy : '0);

    always_ff @(posedge i_clk) begin
        if (in_fire && in_op == admx_pkg::OP_MAP
            && 32'(in_index) < 32'(admx_pkg::MAX_OUT_CHANNELS)) begin
            r_map[in_index[admx_pkg::ROW_W-1:0]] <= in_map;
        end

        r_samp_d <= cell_q[0];

        if (sweeping && r_step == copy_tgt) begin
            r_copy <= cell_q[0];
        end

        if (final_fire && count_bad) begin
            r_out_ch     <= '0;
            r_out_sample <= '0;
            r_out_last   <= 1'b1;
            r_out_err    <= 1'b1;
        end else if (r_state == admx_pkg::ST_DRAIN
                  && r_drain == 2'(admx_pkg::DRAIN_LAST)) begin
            r_out_ch     <= admx_pkg::OUT_CH_BITS'(r_row);
            r_out_sample <= row_result;
            r_out_last   <= row_last;
            r_out_err    <= 1'b0;
        end
    end

    // sample ring: cell 0 is the head, the ring turns once per row
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        admx_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (sample_fire && (32'(r_col_cnt) == g)),
            .i_load_data  (in_sample),
            .i_shift      (sweeping),
            .i_shift_data (cell_q[(g + 1) % NCELL]),
            .o_q          (cell_q[g])
        );
    end

    admx_ram #(
        .WIDTH (admx_pkg::COEF_BITS),
        .DEPTH (admx_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && in_op == admx_pkg::OP_COEF),
        .i_waddr (in_index[admx_pkg::COEF_AW-1:0]),
        .i_wdata (in_coef),
        .i_raddr (r_addr),
        .o_rdata (coef_q)
    );

    // registered ram read data lines up with the registered copy of the head sample
    logic r_mac_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_vld <= 1'b0;
        end else begin
            r_mac_vld <= sweeping && proj_mode && (32'(r_step) < 32'(r_in_columns));
        end
    end

    assign mac_ctrl.clear = sweeping && (r_step == '0);
    assign mac_ctrl.valid = r_mac_vld;

    admx_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_sample (r_samp_d),
        .i_coef   ($signed(coef_q)),
        .o_acc    (acc)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(admx_pkg::OUT_TDATA_W - admx_pkg::OUT_CH_BITS - SB)'(0),
                            r_out_sample, r_out_ch};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> hdl/admx_ram.sv
// admx_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module admx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/admx_cell.sv
// admx_cell: one sample cell of the rotating sample ring
// depends on admx_pkg
`default_nettype none

module admx_cell (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_load,
    input  wire logic signed [admx_pkg::SAMPLE_BITS-1:0] i_load_data,
    input  wire logic                                  i_shift,
    input  wire logic signed [admx_pkg::SAMPLE_BITS-1:0] i_shift_data,
    output logic signed      [admx_pkg::SAMPLE_BITS-1:0] o_q
);

    logic signed [admx_pkg::SAMPLE_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_load_data;
        end else if (i_shift) begin
            r_q <= i_shift_data;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

>>> hdl/admx_mac.sv
// admx_mac: registered multiply then accumulate for one matrix row
// depends on admx_pkg
`default_nettype none

module admx_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire admx_pkg::t_mac_ctrl                    i_ctrl,
    input  wire logic signed [admx_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [admx_pkg::COEF_BITS-1:0]   i_coef,
    output logic signed      [admx_pkg::ACC_W-1:0]       o_acc
);

    localparam int PROD_W = admx_pkg::SAMPLE_BITS + admx_pkg::COEF_BITS;

    logic signed [PROD_W-1:0]          r_prod;
    logic                              r_prod_vld;
    logic signed [admx_pkg::ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + admx_pkg::ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// tb_top: self-checking bench for ambisonics_demix_matrix_unit, a demixing stage
// that turns one instant of input channels into projected, mapped or copied outputs
// depends on admx_pkg and the rtl in hdl/; a built-in predictor checks every beat
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import admx_pkg::*;

    localparam logic [OP_BITS-1:0] OP_NONE    = 2'd3;  // ignored by the block
    localparam logic [1:0]         MODE_SPARE = 2'd3;  // behaves as passthrough
    localparam int  DRAIN_CYCLES = 40;
    localparam int  ITEM_TARGET  = 480;
    localparam longint SMP_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SMP_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = SMP_HI[SAMPLE_BITS-1:0];
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = SMP_LO[SAMPLE_BITS-1:0];
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN = 16'sh8000;
    localparam logic signed [COEF_BITS-1:0]   COEF_MAX = 16'sh7fff;

    typedef struct {
        logic [OUT_CH_BITS-1:0]        chan;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          lst;
        logic                          err;
    } t_demix_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;   // index, coef, map_value, sample
    logic [OP_BITS-1:0] s_axis_tuser;      // op
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // out_channel, out_sample, zero fill
    logic m_axis_tuser;                    // error
    logic m_axis_tlast;

    ambisonics_demix_matrix_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0]              cfg_mode;
    logic [CFG_W-1:0]        cfg_rows;
    logic [CFG_W-1:0]        cfg_cols;
    logic signed [SAMPLE_BITS-1:0] chan_buf [MAX_IN_COLUMNS];
    logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
    logic [MAP_BITS-1:0]           map_mem  [MAX_OUT_CHANNELS];
    bit                            coef_set [COEF_DEPTH];
    bit                            map_set  [MAX_OUT_CHANNELS];
    logic [CNT_BITS-1:0]           chan_cnt;

    t_demix_row pending_rows[$];
    int  n_fail;
    int  n_items;
    bit  in_idle_on;
    bit  out_stall_on;
    int  stall_left;

    function automatic int eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_OUT_CHANNELS) return MAX_OUT_CHANNELS;
        return int'(cfg_rows);
    endfunction

    // items the full matrix test still has to send, counting three of its four instants
    function automatic int full_matrix_cost();
        int c;
        c = 3 * MAX_IN_COLUMNS;
        foreach (coef_set[i]) if (!coef_set[i]) c++;
        foreach (map_set[i]) if (!map_set[i]) c++;
        return c;
    endfunction

    // advance the predicted block by one accepted beat
    function automatic void demix_step(
        input logic [OP_BITS-1:0] op,
        input logic [INDEX_BITS-1:0] idx,
        input logic signed [COEF_BITS-1:0] cf,
        input logic [MAP_BITS-1:0] mv,
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic lst
    );
        t_demix_row row;
        logic [CNT_BITS-1:0] cnt;
        logic [MAP_BITS-1:0] m;
        longint acc;
        longint s;
        int rows;
        case (op)
            OP_COEF: begin
                coef_mem[idx] = cf;
                coef_set[idx] = 1'b1;
            end
            OP_MAP: begin
                if (idx < MAX_OUT_CHANNELS) begin
                    map_mem[idx] = mv;
                    map_set[idx] = 1'b1;
                end
            end
            OP_SAMPLE: begin
                if (chan_cnt < MAX_IN_COLUMNS) chan_buf[chan_cnt] = smp;
                if (chan_cnt != CNT_MAX) chan_cnt = chan_cnt + 1'b1;
                if (lst) begin
                    cnt = chan_cnt;
                    chan_cnt = '0;
                    if (cnt != cfg_cols || cfg_cols > MAX_IN_COLUMNS) begin
                        row.chan = '0;
                        row.smp  = '0;
                        row.lst  = 1'b1;
                        row.err  = 1'b1;
                        pending_rows.push_back(row);
                    end else begin
                        rows = eff_rows();
                        for (int r = 0; r < rows; r++) begin
                            s = 0;
                            if (cfg_mode == MODE_PROJ) begin
                                acc = 0;
                                for (int l = 0; l < int'(cfg_cols); l++)
                                    acc += longint'(chan_buf[l]) *
                                           longint'(coef_mem[(l * rows + r) % COEF_DEPTH]);
                                s = (acc + 64'sd16384) >>> 15;
                                if (s > SMP_HI) s = SMP_HI;
                                if (s < SMP_LO) s = SMP_LO;
                            end else if (cfg_mode == MODE_MONO) begin
                                m = map_mem[r];
                                if (m != SILENT_ENTRY && m < cfg_cols) s = chan_buf[m];
                            end else if (r < int'(cfg_cols)) begin
                                s = chan_buf[r];
                            end
                            row.chan = r[OUT_CH_BITS-1:0];
                            row.smp  = s[SAMPLE_BITS-1:0];
                            row.lst  = (r == rows - 1);
                            row.err  = 1'b0;
                            pending_rows.push_back(row);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // result beats against the oldest prediction
    always @(posedge i_clk) begin : check_rows
        t_demix_row want;
        logic [OUT_TDATA_W-OUT_CH_BITS-SAMPLE_BITS-1:0] fill;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected beat: out_channel %0d out_sample %0d",
                       m_axis_tdata[OUT_CH_BITS-1:0],
                       $signed(m_axis_tdata[OUT_CH_BITS +: SAMPLE_BITS]));
                n_fail++;
            end else begin
                want = pending_rows.pop_front();
                fill = m_axis_tdata[OUT_TDATA_W-1:OUT_CH_BITS+SAMPLE_BITS];
                if (m_axis_tdata[OUT_CH_BITS-1:0] !== want.chan) begin
                    $error("out_channel: expected %0d, got %0d", want.chan,
                           m_axis_tdata[OUT_CH_BITS-1:0]);
                    n_fail++;
                end
                if (m_axis_tdata[OUT_CH_BITS +: SAMPLE_BITS] !== want.smp) begin
                    $error("out_sample: expected %0d, got %0d", want.smp,
                           $signed(m_axis_tdata[OUT_CH_BITS +: SAMPLE_BITS]));
                    n_fail++;
                end
                if (fill !== '0) begin
                    $error("zero fill: expected 0, got %0h", fill);
                    n_fail++;
                end
                if (m_axis_tlast !== want.lst) begin
                    $error("last_out: expected %0d, got %0d", want.lst, m_axis_tlast);
                    n_fail++;
                end
                if (m_axis_tuser !== want.err) begin
                    $error("error: expected %0d, got %0d", want.err, m_axis_tuser);
                    n_fail++;
                end
            end
        end
    end

    // receiver back-pressure in short bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (out_stall_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(
        input logic [OP_BITS-1:0] op,
        input logic [INDEX_BITS-1:0] idx,
        input logic signed [COEF_BITS-1:0] cf,
        input logic [MAP_BITS-1:0] mv,
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic lst
    );
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IDX_LSB +: INDEX_BITS]  = idx;
        d[COEF_LSB +: COEF_BITS]  = cf;
        d[MAP_LSB +: MAP_BITS]    = mv;
        d[SMP_LSB +: SAMPLE_BITS] = smp;
        @(negedge i_clk);
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        demix_step(op, idx, cf, mv, smp, lst);
        if (op == OP_SAMPLE || op == OP_COEF || (op == OP_MAP && idx < MAX_OUT_CHANNELS))
            n_items++;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_smp();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic lst);
        send_beat(OP_SAMPLE, INDEX_BITS'($urandom), COEF_BITS'($urandom),
                  MAP_BITS'($urandom), smp, lst);
    endtask

    task automatic send_coef(input logic [INDEX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] cf);
        send_beat(OP_COEF, idx, cf, MAP_BITS'($urandom), SAMPLE_BITS'($urandom),
                  1'($urandom));
    endtask

    task automatic send_map(input logic [INDEX_BITS-1:0] idx, input logic [MAP_BITS-1:0] mv);
        send_beat(OP_MAP, idx, COEF_BITS'($urandom), mv, SAMPLE_BITS'($urandom),
                  1'($urandom));
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data  <= v;
        @(posedge i_clk);
        case (ri)
            REG_MODE:    cfg_mode = v[1:0];
            REG_OUT_CH:  cfg_rows = v;
            REG_IN_COLS: cfg_cols = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_shape(input logic [1:0] md, input logic [CFG_W-1:0] rows,
                             input logic [CFG_W-1:0] cols);
        set_reg(REG_MODE, CFG_W'(md));
        set_reg(REG_OUT_CH, rows);
        set_reg(REG_IN_COLS, cols);
    endtask

    // sender holds off until every predicted row has come out and the block settles
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // load whatever coefficients or map entries the current shape will read
    task automatic fill_tables();
        int rows;
        int a;
        rows = eff_rows();
        if (cfg_mode == MODE_PROJ && cfg_cols >= 1 && cfg_cols <= MAX_IN_COLUMNS) begin
            for (int r = 0; r < rows; r++)
                for (int l = 0; l < int'(cfg_cols); l++) begin
                    a = (l * rows + r) % COEF_DEPTH;
                    if (!coef_set[a]) send_coef(a[INDEX_BITS-1:0], rand_coef());
                end
        end
        if (cfg_mode == MODE_MONO) begin
            for (int r = 0; r < rows; r++)
                if (!map_set[r]) begin
                    case ($urandom_range(0, 5))
                        0: send_map(r[INDEX_BITS-1:0], SILENT_ENTRY);
                        1: send_map(r[INDEX_BITS-1:0], MAP_BITS'($urandom_range(0, 254)));
                        default: send_map(r[INDEX_BITS-1:0],
                                          MAP_BITS'($urandom_range(0, MAX_IN_COLUMNS - 1)));
                    endcase
                end
        end
    endtask

    task automatic test_defaults();
        // reset shape: passthrough, one row, one column
        send_sample(SMP_MAX, 1'b1);
        send_beat(OP_NONE, 8'hff, COEF_MIN, 8'hff, SMP_MIN, 1'b1);
        send_sample(SMP_MIN, 1'b1);
        wait_drained();
    endtask

    task automatic test_count_errors();
        send_sample(rand_smp(), 1'b0);
        send_sample(rand_smp(), 1'b1);
        send_map(8'd200, 8'd7);
        wait_drained();
        // columns above the maximum can never match
        set_reg(REG_IN_COLS, 5'd20);
        send_sample(rand_smp(), 1'b1);
        wait_drained();
    endtask

    task automatic test_row_limits();
        // zero rows acts as one, spare mode as passthrough
        set_shape(MODE_SPARE, 5'd0, 5'd2);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        wait_drained();
        set_reg(REG_OUT_CH, 5'd31);
        send_sample(rand_smp(), 1'b0);
        send_sample(rand_smp(), 1'b1);
        wait_drained();
    endtask

    task automatic test_mono_map();
        set_shape(MODE_MONO, 5'd4, 5'd3);
        send_map(8'd0, 8'd2);
        send_map(8'd1, SILENT_ENTRY);
        send_map(8'd2, 8'd3);        // equal to the column count, so silent
        send_map(8'd3, 8'd0);
        send_sample(rand_smp(), 1'b0);
        send_sample(rand_smp(), 1'b0);
        send_sample(rand_smp(), 1'b1);
        wait_drained();
    endtask

    task automatic test_projection_saturation();
        set_shape(MODE_PROJ, 5'd1, 5'd2);
        send_coef(8'd0, COEF_MIN);
        send_coef(8'd1, COEF_MIN);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MAX, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_mix();
        logic [1:0] md;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        int n;
        // leave room for the full matrix test in the item budget
        while (n_items + full_matrix_cost() < ITEM_TARGET) begin
            wait_drained();
            case ($urandom_range(0, 9))
                0, 1, 2: md = MODE_PASS;
                3, 4, 5: md = MODE_MONO;
                6, 7, 8: md = MODE_PROJ;
                default: md = MODE_SPARE;
            endcase
            case ($urandom_range(0, 9))
                0: rows = CFG_W'($urandom_range(0, 1) ? 0 : $urandom_range(16, 31));
                1, 2: rows = CFG_W'($urandom_range(1, 16));
                default: rows = CFG_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0: cols = CFG_W'($urandom_range(0, 1) ? 0 : $urandom_range(16, 31));
                1, 2: cols = CFG_W'($urandom_range(1, 16));
                default: cols = CFG_W'($urandom_range(1, 6));
            endcase
            set_shape(md, rows, cols);
            in_idle_on   = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            fill_tables();
            repeat ($urandom_range(2, 6)) begin
                // mostly well-formed instants, some with a wrong channel count
                if (cols >= 1 && cols <= MAX_IN_COLUMNS && $urandom_range(0, 5) != 0)
                    n = cols;
                else
                    n = $urandom_range(1, 40);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        case ($urandom_range(0, 2))
                            0: send_beat(OP_NONE, INDEX_BITS'($urandom), rand_coef(),
                                         MAP_BITS'($urandom), rand_smp(), 1'($urandom));
                            1: send_coef(INDEX_BITS'($urandom), rand_coef());
                            default: send_map(INDEX_BITS'($urandom), MAP_BITS'($urandom));
                        endcase
                    end
                    send_sample(rand_smp(), k == n - 1);
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_full_matrix();
        in_idle_on   = 1'b0;
        out_stall_on = 1'b0;
        set_shape(MODE_PROJ, 5'd16, 5'd16);
        fill_tables();
        repeat (2) begin
            for (int k = 0; k < MAX_IN_COLUMNS; k++)
                send_sample(rand_smp(), k == MAX_IN_COLUMNS - 1);
        end
        wait_drained();
        set_reg(REG_MODE, CFG_W'(MODE_MONO));
        fill_tables();
        for (int k = 0; k < MAX_IN_COLUMNS; k++)
            send_sample(rand_smp(), k == MAX_IN_COLUMNS - 1);
        wait_drained();
        set_reg(REG_MODE, CFG_W'(MODE_PASS));
        for (int k = 0; k < MAX_IN_COLUMNS; k++)
            send_sample(rand_smp(), k == MAX_IN_COLUMNS - 1);
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SAMPLE;
        s_axis_tlast  = 1'b0;
        cfg_mode      = MODE_PASS;
        cfg_rows      = CFG_W'(1);
        cfg_cols      = CFG_W'(1);
        chan_cnt      = '0;
        n_fail        = 0;
        n_items       = 0;
        in_idle_on    = 1'b1;
        out_stall_on  = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_count_errors();
        test_row_limits();
        test_mono_map();
        test_projection_saturation();
        test_random_mix();
        test_full_matrix();

        if (n_fail == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/admx_pkg.sv
hdl/admx_ram.sv
hdl/admx_cell.sv
hdl/admx_mac.sv
hdl/ambisonics_demix_matrix_unit.sv
verif/tb_top.sv
